[hw/rtl/jrld_pkg.sv]
// shared types, codes and constants for the run-length dequantiser
// no dependencies
package jrld_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_RESCALE = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_AC      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RD,
    ST_WR
  } state_e;

  typedef struct packed {
    func_e              func;
    logic               table_sel;
    logic [5:0]         entry_index;
    logic [7:0]         entry_value;
    logic [7:0]         scale_factor;
    logic signed [15:0] dc_value;
    logic [3:0]         run_length;
    logic [3:0]         value_size;
    logic [14:0]        raw_bits;
  } in_t;

  typedef struct packed {
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic               block_last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic sweep_step;
    logic coef_rd;
    logic coef_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ac_full;
    logic sweep_last;
    logic item_done;
    logic out_free;
  } sts_t;

  localparam logic [5:0] AC_SLOTS       = 6'd63;
  localparam logic [7:0] CLAMP_HI       = 8'hFE;
  localparam logic [3:0] ZRL_RUN        = 4'hF;
  localparam logic [6:0] CHROMA_DC_ADDR = 7'd64;

  // zigzag order of the ac slots, last entry is never read
  localparam logic [5:0] SCAN_ORDER [64] = '{
     6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10, 6'd17,
    6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5, 6'd12,
    6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34, 6'd27,
    6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28, 6'd35,
    6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36, 6'd29,
    6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51, 6'd58,
    6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46, 6'd53,
    6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63, 6'd63
  };

  // jpeg style sign extension of the raw magnitude bits
  function automatic logic [15:0] level_decode(input logic [3:0] size,
                                               input logic [14:0] raw);
    logic [15:0] mask;
    logic [15:0] mag;
    mask = (16'd1 << size) - 16'd1;
    mag  = {1'b0, raw} & mask;
    if (size != 4'd0 && mag <= (mask >> 1)) begin
      return mag - mask;
    end
    return mag;
  endfunction

endpackage

[hw/rtl/jrld_ctrl.sv]
// controller state machine of the run-length dequantiser
// depends on jrld_pkg
module jrld_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jrld_pkg::func_e in_func_i,
  input  jrld_pkg::sts_t sts_i,
  output jrld_pkg::cmd_t cmd_o
);
  import jrld_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (in_func_i)
            FUNC_LOAD:    state_d = ST_IDLE;
            FUNC_RESCALE: state_d = ST_SWEEP;
            FUNC_START:   state_d = ST_RD;
            FUNC_AC:      state_d = sts_i.ac_full ? ST_IDLE : ST_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.coef_rd = 1'b1;
        state_d       = ST_WR;
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          cmd_o.coef_wr = 1'b1;
          state_d       = sts_i.item_done ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/jrld_datapath.sv]
// datapath: quantiser tables, rescale sweep, run expansion, output register
// depends on jrld_pkg
module jrld_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jrld_pkg::in_t  in_i,
  input  jrld_pkg::cmd_t cmd_i,
  output jrld_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jrld_pkg::out_t out_o
);
  import jrld_pkg::*;

  // tables, entry = table * 64 + position
  logic [7:0]   base_mem [128];
  logic [7:0]   act_mem  [128];
  logic [127:0] base_vld_q;
  logic [127:0] act_vld_q;

  logic [7:0]  base_rd_q;
  logic        base_rd_vld_q;
  logic [7:0]  act_rd_q;
  logic        act_rd_vld_q;

  logic [7:0]  sweep_cnt_q;
  logic [7:0]  factor_q;

  logic [5:0]  ac_pos_q;
  logic        block_table_q;
  logic        dc_mode_q;
  logic        eob_q;
  logic [3:0]  zr_q;
  logic [15:0] level_q;

  logic [5:0]  cur_pos_q;
  logic [15:0] cur_level_q;
  logic        cur_last_q;
  logic        cur_done_q;

  logic        out_valid_q;
  out_t        out_data_q;

  logic        load_we;
  logic        base_we;
  logic        act_we;
  logic [6:0]  act_wa;
  logic [7:0]  act_wd;
  logic [6:0]  load_addr;
  logic [6:0]  sweep_wa;
  logic [7:0]  base_val;
  logic [15:0] scaled;
  logic [7:0]  clamped;
  logic [15:0] in_level;

  logic [5:0]  rd_pos;
  logic [6:0]  rd_addr;
  logic [15:0] emit_level;
  logic        emit_last;
  logic        emit_done;
  logic [7:0]  quant;
  logic [15:0] product;
  logic        out_free;

  assign load_addr = {in_i.table_sel, in_i.entry_index};
  assign load_we   = cmd_i.take && (in_i.func == FUNC_LOAD);
  assign base_we   = load_we;
  assign in_level  = level_decode(in_i.value_size, in_i.raw_bits);

  // rescale sweep: read base at count, write active one entry behind
  assign sweep_wa = 7'(sweep_cnt_q - 8'd1);
  assign base_val = base_rd_vld_q ? base_rd_q : 8'd0;
  assign scaled   = (sweep_wa == CHROMA_DC_ADDR) ? (16'(base_val) >> 2)
                  : ((16'(base_val) * 16'(factor_q)) >> 2);

  always_comb begin
    if (scaled == 16'd0) begin
      clamped = 8'd1;
    end else if (scaled > 16'(CLAMP_HI)) begin
      clamped = CLAMP_HI;
    end else begin
      clamped = scaled[7:0];
    end
  end

  assign act_we = load_we || (cmd_i.sweep_step && sweep_cnt_q != 8'd0);
  assign act_wa = load_we ? load_addr : sweep_wa;
  assign act_wd = load_we ? in_i.entry_value : clamped;

  // next coefficient of the current item
  assign rd_pos     = dc_mode_q ? 6'd0 : SCAN_ORDER[ac_pos_q];
  assign rd_addr    = {block_table_q, rd_pos};
  assign emit_level = (dc_mode_q || (!eob_q && zr_q == 4'd0)) ? level_q : 16'd0;
  assign emit_last  = !dc_mode_q && (ac_pos_q == AC_SLOTS - 6'd1);
  assign emit_done  = dc_mode_q || emit_last || (!eob_q && zr_q == 4'd0);

  assign quant   = act_rd_vld_q ? act_rd_q : 8'd0;
  assign product = 16'(quant) * cur_level_q;

  assign out_free = !out_valid_q || out_ready_i;

  // memories
  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[load_addr] <= in_i.entry_value;
    end
    if (cmd_i.sweep_step && !sweep_cnt_q[7]) begin
      base_rd_q <= base_mem[sweep_cnt_q[6:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    if (cmd_i.coef_rd) begin
      act_rd_q <= act_mem[rd_addr];
    end
  end

  // per-entry valid bits stand in for the zero reset of the tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vld_q    <= '0;
      act_vld_q     <= '0;
      base_rd_vld_q <= 1'b0;
      act_rd_vld_q  <= 1'b0;
    end else begin
      if (base_we) begin
        base_vld_q[load_addr] <= 1'b1;
      end
      if (act_we) begin
        act_vld_q[act_wa] <= 1'b1;
      end
      if (cmd_i.sweep_step && !sweep_cnt_q[7]) begin
        base_rd_vld_q <= base_vld_q[sweep_cnt_q[6:0]];
      end
      if (cmd_i.coef_rd) begin
        act_rd_vld_q <= act_vld_q[rd_addr];
      end
    end
  end

  // item and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_pos_q      <= '0;
      block_table_q <= 1'b0;
      dc_mode_q     <= 1'b0;
      eob_q         <= 1'b0;
      zr_q          <= '0;
      sweep_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        unique case (in_i.func)
          FUNC_RESCALE: sweep_cnt_q <= '0;
          FUNC_START: begin
            block_table_q <= in_i.table_sel;
            ac_pos_q      <= '0;
            dc_mode_q     <= 1'b1;
          end
          FUNC_AC: begin
            dc_mode_q <= 1'b0;
            eob_q     <= (in_level == 16'd0) && (in_i.run_length == 4'd0);
            zr_q      <= ((in_level == 16'd0) && (in_i.run_length == 4'd1))
                         ? ZRL_RUN : in_i.run_length;
          end
          default: ;
        endcase
      end
      if (cmd_i.sweep_step) begin
        sweep_cnt_q <= sweep_cnt_q + 8'd1;
      end
      if (cmd_i.coef_rd && !dc_mode_q) begin
        ac_pos_q <= ac_pos_q + 6'd1;
        if (!eob_q && zr_q != 4'd0) begin
          zr_q <= zr_q - 4'd1;
        end
      end
      if (cmd_i.coef_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      factor_q <= in_i.scale_factor;
      level_q  <= (in_i.func == FUNC_START) ? $unsigned(in_i.dc_value) : in_level;
    end
    if (cmd_i.coef_rd) begin
      cur_pos_q   <= rd_pos;
      cur_level_q <= emit_level;
      cur_last_q  <= emit_last;
      cur_done_q  <= emit_done;
    end
    if (cmd_i.coef_wr) begin
      out_data_q.coef_index <= cur_pos_q;
      out_data_q.coef_value <= product;
      out_data_q.block_last <= cur_last_q;
    end
  end

  assign sts_o.ac_full    = (ac_pos_q == AC_SLOTS);
  assign sts_o.sweep_last = sweep_cnt_q[7];
  assign sts_o.item_done  = cur_done_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_data_q;

  a_wr_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.coef_wr |-> (!out_valid_q || out_ready_i))
    else $error("coefficient loaded over an untaken word");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.block_last) |-> (out_data_q.coef_index == 6'd63))
    else $error("block_last away from the final position");

  a_rd_then_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.coef_rd |=> !cmd_i.coef_rd)
    else $error("two table reads without a write between");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep_step || cmd_i.coef_rd) |-> !cmd_i.take)
    else $error("word taken while busy");

endmodule

[hw/rtl/jpeg_like_run_length_dequantizer.sv]
// top level of the zigzag run-length dequantiser for 8x8 blocks
// depends on jrld_pkg, jrld_ctrl, jrld_datapath
// load word: one entry into the base and active tables; rescale: one table entry per cycle over both tables
// block start and each ac coefficient: table read, then multiply into the output register
// once that register is free; up to 63 coefficients per symbol
// reset: tables read as zero through per-entry valid bits, ac position 0, luma table
module jpeg_like_run_length_dequantizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jrld_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jrld_pkg::out_t out_o
);
  import jrld_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts a word only when idle, then runs the sweep
  // or the read/write pairs that expand one symbol into coefficients
  jrld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_func_i  (in_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: quantiser tables, run counters and the output register,
  // which lets the next word in while a coefficient waits downstream
  jrld_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[tb/jpeg_like_run_length_dequantizer_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the zigzag run-length dequantiser top level
// depends on jrld_pkg and jpeg_like_run_length_dequantizer; predicts every coefficient
// word from the accepted input words and checks it against the output channel
module jpeg_like_run_length_dequantizer_tb;
  import jrld_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000; // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 160;  // covers a full rescale sweep
  localparam int RANDOM_WORDS   = 200;

  // natural-order position of each ac slot, own copy of the zigzag scan
  localparam logic [5:0] ZIGZAG_POS [63] = '{
     6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10, 6'd17,
    6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5, 6'd12,
    6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34, 6'd27,
    6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28, 6'd35,
    6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36, 6'd29,
    6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51, 6'd58,
    6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46, 6'd53,
    6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // mirror of the quantiser tables and block position, plus the queue of
  // coefficient words still owed by the block
  class dequant_scoreboard;
    logic [7:0] base_q   [128];
    logic [7:0] active_q [128];
    logic [5:0] ac_slot;
    logic       blk_tbl;
    out_t       pending_coefs [$];
    int         errors;

    function new();
      foreach (base_q[i]) begin
        base_q[i]   = 8'd0;
        active_q[i] = 8'd0;
      end
      ac_slot = 6'd0;
      blk_tbl = 1'b0;
      errors  = 0;
    endfunction

    function bit drained();
      return pending_coefs.size() == 0;
    endfunction

    function void push_coef(logic [5:0] pos, logic [15:0] level, logic last);
      out_t        c;
      logic [15:0] q;
      q = {8'd0, active_q[{blk_tbl, pos}]};
      c.coef_index = pos;
      c.coef_value = q * level; // wraps to 16 bits
      c.block_last = last;
      pending_coefs.push_back(c);
    endfunction

    function void fill_slot(logic [15:0] level);
      logic [5:0] pos;
      pos     = ZIGZAG_POS[ac_slot];
      ac_slot = ac_slot + 6'd1;
      push_coef(pos, level, ac_slot == AC_SLOTS);
    endfunction

    // jpeg sign extension: top raw bit clear means a negative level
    function logic [15:0] decode_level(logic [3:0] size, logic [14:0] raw);
      logic [15:0] top;
      logic [15:0] mag;
      if (size == 4'd0) return 16'd0;
      top = 16'd1 << size;
      mag = {1'b0, raw} & (top - 16'd1);
      if (mag < (top >> 1)) return mag + 16'd1 - top;
      return mag;
    endfunction

    function logic [7:0] clamp_entry(logic [15:0] v);
      if (v == 16'd0) return 8'd1;
      if (v > {8'd0, CLAMP_HI}) return CLAMP_HI;
      return v[7:0];
    endfunction

    // returns 0 when the word has no effect at all
    function bit note_word(in_t w);
      logic [15:0] lvl;
      logic [15:0] prod;
      logic [3:0]  run;
      int          p;
      case (w.func)
        FUNC_LOAD: begin
          base_q[{w.table_sel, w.entry_index}]   = w.entry_value;
          active_q[{w.table_sel, w.entry_index}] = w.entry_value;
        end
        FUNC_RESCALE: begin
          for (p = 0; p < 128; p++) begin
            prod        = base_q[p] * w.scale_factor;
            active_q[p] = clamp_entry(prod >> 2);
          end
          // chroma dc ignores the factor
          active_q[CHROMA_DC_ADDR] = clamp_entry({8'd0, base_q[CHROMA_DC_ADDR]} >> 2);
        end
        FUNC_START: begin
          blk_tbl = w.table_sel;
          ac_slot = 6'd0;
          push_coef(6'd0, w.dc_value, 1'b0);
        end
        FUNC_AC: begin
          if (ac_slot >= AC_SLOTS) return 1'b0;
          lvl = decode_level(w.value_size, w.raw_bits);
          run = w.run_length;
          if (lvl == 16'd0 && run == 4'd0) begin
            while (ac_slot < AC_SLOTS) fill_slot(16'd0);
            return 1'b1;
          end
          if (lvl == 16'd0 && run == 4'd1) run = ZRL_RUN;
          while (run > 4'd0 && ac_slot < AC_SLOTS) begin
            fill_slot(16'd0);
            run = run - 4'd1;
          end
          if (ac_slot < AC_SLOTS) fill_slot(lvl);
        end
      endcase
      return 1'b1;
    endfunction

    function void flag(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_coef(out_t got);
      out_t want;
      if (pending_coefs.size() == 0) begin
        errors++;
        $display("%0t: unexpected coefficient: expected none, got idx %0d value %0d last %0b",
                 $time, got.coef_index, got.coef_value, got.block_last);
        return;
      end
      want = pending_coefs.pop_front();
      if (got.coef_index !== want.coef_index)
        flag("coef_index", int'(want.coef_index), int'(got.coef_index));
      if (got.coef_value !== want.coef_value)
        flag("coef_value", int'(want.coef_value), int'(got.coef_value));
      if (got.block_last !== want.block_last)
        flag("block_last", int'(want.block_last), int'(got.block_last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  dequant_scoreboard sb;
  bit idle_en;            // random idling on both sides while set
  int words_left;         // effective words still to send in the random part
  int stall_left = 0;     // remaining cycles of the current output stall
  int quiet_cycles = 0;   // cycles since the last accepted word on either side

  always #4 clk_i = ~clk_i;

  jpeg_like_run_length_dequantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // receiver: ready, with random stall bursts while idling is enabled
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // output monitor and watchdog; values are sampled as they stood before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && out_ready_i) sb.check_coef(out_o);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // random content in every field, then the function code on top
  function automatic in_t rand_word(func_e f);
    in_t w;
    w      = in_t'({$urandom(), $urandom()});
    w.func = f;
    return w;
  endfunction

  // drive one word and hold it until the block takes it; valid is only
  // lowered when a gap is wanted, so it never toggles within one edge
  task automatic send_word(in_t w);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (sb.note_word(w)) words_left--;
  endtask

  task automatic load_entry(logic tbl, logic [5:0] idx, logic [7:0] val);
    in_t w;
    w             = rand_word(FUNC_LOAD);
    w.table_sel   = tbl;
    w.entry_index = idx;
    w.entry_value = val;
    send_word(w);
  endtask

  task automatic rescale(logic [7:0] factor);
    in_t w;
    w              = rand_word(FUNC_RESCALE);
    w.scale_factor = factor;
    send_word(w);
  endtask

  task automatic start_block(logic tbl, logic [15:0] dc);
    in_t w;
    w           = rand_word(FUNC_START);
    w.table_sel = tbl;
    w.dc_value  = dc;
    send_word(w);
  endtask

  task automatic ac_symbol(logic [3:0] run, logic [3:0] size, logic [14:0] raw);
    in_t w;
    w            = rand_word(FUNC_AC);
    w.run_length = run;
    w.value_size = size;
    w.raw_bits   = raw;
    send_word(w);
  endtask

  // mostly short runs, and size zero only now and then so blocks run on
  task automatic rand_ac();
    logic [3:0] run;
    logic [3:0] size;
    run  = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    size = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    ac_symbol(run, size, 15'($urandom()));
  endtask

  initial begin
    int  i;
    int  n;
    int  pick;
    bit  paused;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    idle_en      = 1'b1;
    paused       = 1'b0;
    sb           = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // ac symbol straight after reset decodes into a luma block of zero entries
    ac_symbol(4'd0, 4'd3, 15'd5);
    load_entry(1'b0, 6'd1, 8'hFF);
    load_entry(1'b0, 6'd0, 8'hFF);
    load_entry(1'b0, 6'd63, 8'h00);
    load_entry(1'b1, 6'd0, 8'hFF);
    load_entry(1'b1, 6'd63, 8'h01);
    load_entry(1'b0, 6'd8, 8'h80);
    // still in the block begun before any start
    ac_symbol(4'd0, 4'd15, 15'h7FFF);
    // start abandons it; most negative dc
    start_block(1'b0, 16'h8000);
    ac_symbol(4'd0, 4'd15, 15'h7FFF);  // largest positive level
    ac_symbol(4'd0, 4'd15, 15'h0000);  // largest negative level
    ac_symbol(4'd0, 4'd1, 15'h7FFE);   // minus one
    ac_symbol(4'd0, 4'd1, 15'h0001);   // plus one
    ac_symbol(4'd15, 4'd4, 15'h0003);  // longest run before a value
    ac_symbol(4'd1, 4'd0, 15'h2AAA);   // sixteen zeros
    ac_symbol(4'd5, 4'd0, 15'h5555);   // zero level after a run
    ac_symbol(4'd0, 4'd0, 15'h7FFF);   // end of block
    ac_symbol(4'd3, 4'd7, 15'h0040);   // ignored, block already finished
    start_block(1'b1, 16'h7FFF);
    // sixteen-zero runs until the block fills and stops on the last slot
    repeat (4) ac_symbol(4'd1, 4'd0, 15'd0);
    rescale(8'd0);                      // every entry but chroma dc clamps to one
    start_block(1'b1, 16'hFFFF);
    rescale(8'd239);                    // top of the range, clamps high
    start_block(1'b0, 16'd2);

    // fill both tables with random bytes so products carry weight
    for (i = 0; i < 128; i++) load_entry(i[6], i[5:0], 8'($urandom_range(0, 255)));

    // random part: mostly well-formed blocks, with loads and rescales as noise
    words_left = RANDOM_WORDS;
    while (words_left > 0) begin
      // a stretch with no idling in the middle, and none at the end
      idle_en = (words_left > 40) && !(words_left < 140 && words_left > 115);
      if (!paused && words_left < 100) begin
        // hold the sender until everything owed has come out
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (!sb.drained());
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_entry(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(0, 255)));
      end else if (pick < 11) begin
        case ($urandom_range(0, 3))
          0:       rescale(8'd0);
          1:       rescale(8'd239);
          default: rescale(8'($urandom_range(0, 239)));
        endcase
      end else begin
        start_block(1'($urandom_range(0, 1)), 16'($urandom()));
        n = $urandom_range(0, 12);
        repeat (n) rand_ac();
        if ($urandom_range(0, 1) == 1) ac_symbol(4'd0, 4'd0, 15'($urandom()));
        if ($urandom_range(0, 9) == 0) rand_ac();
      end
    end

    // wind down: no more words, wait for the last coefficients and a quiet tail
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (!sb.drained());
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[jpeg_like_run_length_dequantizer.f]
hw/rtl/jrld_pkg.sv
hw/rtl/jrld_ctrl.sv
hw/rtl/jrld_datapath.sv
hw/rtl/jpeg_like_run_length_dequantizer.sv
tb/jpeg_like_run_length_dequantizer_tb.sv
